>>> sv/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PTTE_CHECK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("check failed");

// Condition must never be seen outside reset.
`define PTTE_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> sv/ptte_pkg.sv
// Shared types and constants of the pointer to touch event converter.
package ptte_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned DimW        = 12;
  localparam int unsigned RotW        = 2;
  localparam int unsigned GainW       = 28;
  localparam int unsigned LimW        = 24;
  localparam int unsigned HalfW       = DimW - 1;
  localparam int unsigned CfgDataW    = 28;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned OpAW        = LimW + 2;
  localparam int unsigned PosW        = 16;
  localparam int unsigned MapOpW      = PosW + 1;
  localparam int unsigned ProdW       = OpAW + GainW + 2;
  localparam int unsigned ValW        = 32;

  typedef enum logic [CfgAddrW-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_ROTATION = 3'd2,
    REG_X_GAIN   = 3'd3,
    REG_Y_GAIN   = 3'd4,
    REG_DEAD_LIM = 3'd5,
    REG_DEAD_SCL = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_X    = 2'd0,
    KIND_Y    = 2'd1,
    KIND_KEY  = 2'd2,
    KIND_SYNC = 2'd3
  } kind_e;

  // control of the shared multiplier
  typedef struct packed {
    logic load;
    logic sub_half;
  } mul_ctrl_t;

endpackage

>>> sv/ptte_mul.sv
// Shared multiply unit: registered product with optional half-side offset, truncated output.
module ptte_mul #(
  parameter int unsigned FRAC_BITS = ptte_pkg::FracBitsDef
) (
  input  logic                                  clk_i,
  input  ptte_pkg::mul_ctrl_t                   ctrl_i,
  input  logic signed [ptte_pkg::OpAW-1:0]      op_a_i,
  input  logic        [ptte_pkg::GainW-1:0]     op_b_i,
  input  logic        [ptte_pkg::HalfW-1:0]     half_i,
  output logic signed [ptte_pkg::ProdW-FRAC_BITS-1:0] trunc_o
);
  import ptte_pkg::*;

  localparam int unsigned CW = ProdW - FRAC_BITS;
  localparam int unsigned RawW = OpAW + GainW + 1;
  localparam logic signed [ProdW-1:0] Rnd = (ProdW'(1) << FRAC_BITS) - ProdW'(1);

  logic signed [RawW-1:0]  raw;
  logic signed [ProdW-1:0] bias;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [ProdW-1:0] rnd;
  logic signed [ProdW-1:0] shifted;

  assign raw  = op_a_i * $signed({1'b0, op_b_i});
  assign bias = ctrl_i.sub_half ? $signed(ProdW'(half_i) << FRAC_BITS) : '0;
  assign prod_d = ProdW'(raw) - bias;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

  // truncate toward zero
  assign rnd     = prod_q + (prod_q[ProdW-1] ? Rnd : '0);
  assign shifted = rnd >>> FRAC_BITS;
  assign trunc_o = shifted[CW-1:0];

endmodule

>>> sv/pointer_to_touch_events.sv
// Pointer to touch event converter top level.
// Each pointer item (button mask, x, y) is mapped onto a square touch area
// centered on zero for the configured display rotation, dropped when it falls
// in the dead zone of a cropped axis, and turned into a run of touch events:
// press (X, Y, key 1, sync), move (X, Y, sync) or release (key 0, sync);
// tlast marks the sync event that closes a run. All arithmetic goes through
// one shared multiplier: after acceptance an item passes through the two
// axis products, the truncations and the dead zone check, then the rescale
// of the cropped axis where there is one, then one event per cycle (2 to 4
// events) when the output side does not stall, and the block takes the next
// item the cycle after the last event is loaded. Configuration writes belong
// to idle periods only; the user must keep to this, as the block itself
// does not enforce it.
module pointer_to_touch_events #(
  parameter int unsigned FRAC_BITS = ptte_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptte_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [ptte_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [39:0]                     s_axis_tdata,  // button_mask, x_pos, y_pos
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // event_value
  output logic [1:0]                      m_axis_tuser,  // event_kind
  output logic                            m_axis_tlast
);
  import ptte_pkg::*;

  localparam int unsigned CW = ProdW - FRAC_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MX   = 6'b000010,
    S_MY   = 6'b000100,
    S_CHK  = 6'b001000,
    S_DZ   = 6'b010000,
    S_SC   = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    RUN_NONE    = 2'd0,
    RUN_PRESS   = 2'd1,
    RUN_MOVE    = 2'd2,
    RUN_RELEASE = 2'd3
  } run_e;

  typedef struct packed {
    kind_e             kind;
    logic [ValW-1:0]   value;
    logic              last;
  } ev_t;

  // emit state kept apart from the compute sequence
  logic emit_q, emit_d;

  logic [DimW-1:0]  width_q, height_q;
  logic [RotW-1:0]  rot_q;
  logic [GainW-1:0] x_gain_q, y_gain_q, dead_scale_q;
  logic [LimW-1:0]  dead_lim_q;

  state_e state_q, state_d;
  run_e   run_q, run_d;
  logic   touch_q;
  logic   left_q;
  logic [PosW-1:0] x_q, y_q;
  logic signed [CW-1:0] ox_q, oy_q;
  logic [1:0] ev_idx_q;

  logic        out_valid_q;
  ev_t         out_q, ev;
  logic        out_load;

  logic [HalfW-1:0] half;
  logic             landscape, crop_x, crop_y;
  logic signed [MapOpW-1:0] x_op, y_op, wx_op, hy_op;
  logic signed [MapOpW-1:0] map_a;
  logic [GainW-1:0]         map_g;
  mul_ctrl_t                mul_ctrl;
  logic signed [OpAW-1:0]   op_a;
  logic [GainW-1:0]         op_b;
  logic signed [CW-1:0]     trunc_v;
  logic signed [CW-1:0]     crop_v;
  logic signed [CW-1:0]     lim_ext;
  logic                     dropped;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= DimW'(1);
      height_q     <= DimW'(1);
      rot_q        <= '0;
      x_gain_q     <= GainW'(1) << FRAC_BITS;
      y_gain_q     <= GainW'(1) << FRAC_BITS;
      dead_lim_q   <= '0;
      dead_scale_q <= GainW'(1) << FRAC_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_WIDTH:    width_q      <= cfg_wdata_i[DimW-1:0];
        REG_HEIGHT:   height_q     <= cfg_wdata_i[DimW-1:0];
        REG_ROTATION: rot_q        <= cfg_wdata_i[RotW-1:0];
        REG_X_GAIN:   x_gain_q     <= cfg_wdata_i[GainW-1:0];
        REG_Y_GAIN:   y_gain_q     <= cfg_wdata_i[GainW-1:0];
        REG_DEAD_LIM: dead_lim_q   <= cfg_wdata_i[LimW-1:0];
        REG_DEAD_SCL: dead_scale_q <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign landscape = width_q > height_q;
  assign half      = landscape ? width_q[DimW-1:1] : height_q[DimW-1:1];
  assign crop_y    = !landscape && rot_q[0];
  assign crop_x    = landscape && !rot_q[0];

  assign x_op  = $signed({1'b0, x_q});
  assign y_op  = $signed({1'b0, y_q});
  assign wx_op = $signed(MapOpW'(width_q)) - x_op;
  assign hy_op = $signed(MapOpW'(height_q)) - y_op;

  // axis operand: first pass gives X, second pass gives Y
  always_comb begin
    map_a = x_op;
    map_g = x_gain_q;
    if (state_q == S_MX) begin
      case (rot_q)
        2'd0: begin map_a = x_op;  map_g = x_gain_q; end
        2'd1: begin map_a = hy_op; map_g = y_gain_q; end
        2'd2: begin map_a = wx_op; map_g = x_gain_q; end
        default: begin map_a = y_op; map_g = y_gain_q; end
      endcase
    end else begin
      case (rot_q)
        2'd0: begin map_a = y_op;  map_g = y_gain_q; end
        2'd1: begin map_a = x_op;  map_g = x_gain_q; end
        2'd2: begin map_a = hy_op; map_g = y_gain_q; end
        default: begin map_a = wx_op; map_g = x_gain_q; end
      endcase
    end
  end

  assign crop_v  = crop_y ? oy_q : ox_q;
  assign lim_ext = $signed(CW'(dead_lim_q));
  assign dropped = (crop_x || crop_y) && ((crop_v > lim_ext) || (crop_v < -lim_ext));

  always_comb begin
    mul_ctrl.load     = 1'b0;
    mul_ctrl.sub_half = 1'b1;
    op_a              = OpAW'(map_a);
    op_b              = map_g;
    if (state_q == S_DZ) begin
      op_a              = crop_v[OpAW-1:0];
      op_b              = dead_scale_q;
      mul_ctrl.sub_half = 1'b0;
      mul_ctrl.load     = 1'b1;
    end else if (state_q == S_MX || state_q == S_MY) begin
      mul_ctrl.load = 1'b1;
    end
  end

  ptte_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .half_i (half),
    .trunc_o(trunc_v)
  );

  function automatic logic [ValW-1:0] sat32(input logic signed [CW-1:0] v);
    logic [CW-ValW:0] top;
    top = v[CW-1:ValW-1];
    if ((&top) || !(|top)) begin
      sat32 = v[ValW-1:0];
    end else if (v[CW-1]) begin
      sat32 = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(ValW-1){1'b1}}};
    end
  endfunction

  // event of the current run at the current position
  always_comb begin
    ev.kind  = KIND_SYNC;
    ev.value = '0;
    ev.last  = 1'b1;
    case (run_q)
      RUN_PRESS, RUN_MOVE: begin
        case (ev_idx_q)
          2'd0: begin ev.kind = KIND_X; ev.value = sat32(ox_q); ev.last = 1'b0; end
          2'd1: begin ev.kind = KIND_Y; ev.value = sat32(oy_q); ev.last = 1'b0; end
          2'd2: begin
            if (run_q == RUN_PRESS) begin
              ev.kind  = KIND_KEY;
              ev.value = ValW'(1);
              ev.last  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      RUN_RELEASE: begin
        if (ev_idx_q == 2'd0) begin
          ev.kind = KIND_KEY;
          ev.last = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_load = emit_q && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    run_d   = run_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = S_MX;
        end
      end
      S_MX:  state_d = S_MY;
      S_MY:  state_d = S_CHK;
      S_CHK: state_d = S_DZ;
      S_DZ: begin
        if (left_q) begin
          run_d = touch_q ? RUN_MOVE : RUN_PRESS;
        end else begin
          run_d = touch_q ? RUN_RELEASE : RUN_NONE;
        end
        if (dropped || (run_d == RUN_NONE)) begin
          state_d = S_IDLE;
        end else if (crop_x || crop_y) begin
          state_d = S_SC;
        end else begin
          state_d = S_IDLE;
          emit_d  = 1'b1;
        end
      end
      S_SC: begin
        state_d = S_IDLE;
        emit_d  = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
    if (out_load && ev.last) begin
      emit_d = 1'b0;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE) && !emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      emit_q      <= 1'b0;
      run_q       <= RUN_NONE;
      touch_q     <= 1'b0;
      ev_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
      run_q   <= run_d;
      if (state_q == S_DZ) begin
        ev_idx_q <= '0;
      end else if (out_load) begin
        ev_idx_q <= ev_idx_q + 2'd1;
      end
      if (out_load && ev.last) begin
        touch_q <= (run_q != RUN_RELEASE);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      left_q <= s_axis_tdata[0];
      x_q    <= s_axis_tdata[23:8];
      y_q    <= s_axis_tdata[39:24];
    end
    if (state_q == S_MY) begin
      ox_q <= trunc_v;
    end
    if (state_q == S_CHK) begin
      oy_q <= trunc_v;
    end
    if (state_q == S_SC) begin
      if (crop_y) begin
        oy_q <= trunc_v;
      end else begin
        ox_q <= trunc_v;
      end
    end
    if (out_load) begin
      out_q <= ev;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.value;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

`include "assert_macros.svh"

  `PTTE_CHECK(a_accept_starts, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> (state_q == S_MX))
  `PTTE_CHECK(a_last_is_sync, clk_i, rst_ni, (m_axis_tvalid && m_axis_tlast) |-> ((m_axis_tuser == KIND_SYNC) && (m_axis_tdata == '0)))
  `PTTE_CHECK(a_key_is_bit, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tuser == KIND_KEY)) |-> (m_axis_tdata[31:1] == '0))
  `PTTE_CHECK(a_touch_on_emit, clk_i, rst_ni, !$stable(touch_q) |-> $past(emit_q))
  `PTTE_NEVER(a_no_accept_in_run, clk_i, rst_ni, emit_q && (state_q != S_IDLE))

endmodule
